@@ hw/rtl/upd_pkg.sv @@
// Package for the URL percent decoder: character constants and hex digit decoding.
// Self-contained; imported by url_percent_decoder_core.
`timescale 1ns / 1ps

package upd_pkg;

  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_NUL     = 8'h00;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LENGTH_W = 16;
  localparam int unsigned LIMIT_W  = 16;

  typedef struct packed {
    logic       ok;
    logic [3:0] nibble;
  } hex_digit_t;

  // Accepts 0-9, A-F and a-f.
  function automatic hex_digit_t hex_decode(input logic [7:0] b);
    hex_digit_t r;
    r.ok     = 1'b0;
    r.nibble = 4'h0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r.ok     = 1'b1;
      r.nibble = 4'(b - 8'h30);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r.ok     = 1'b1;
      r.nibble = 4'(b - 8'h37);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r.ok     = 1'b1;
      r.nibble = 4'(b - 8'h57);
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/url_percent_decoder_core.sv @@
// Top level of the URL percent decoder: byte stream in, decoded byte stream out.
// Depends on upd_pkg for character constants and hex digit decoding.
`timescale 1ns / 1ps

// The decoder takes one encoded byte per cycle while its input side is ready
// and produces at most one decoded byte per input, so the sustained rate is one
// byte per clock when the output is not stalled. Decoding and the state update
// happen in the cycle a byte is accepted and land in the output register; the
// input side is ready whenever that register is empty or emptied in the same cycle.
// A plus becomes a space, a percent with two hex digits becomes one byte, and
// the zero terminator is passed out with tlast set. Each result carries the
// running length of the string. A bad escape gives a zero byte with tuser set
// and tlast set; reaching output_limit ends the string with tlast set. After
// an early end, input is dropped up to and including the next zero byte. The
// limit register is written through output_limit_we/output_limit_wdata; the user
// must do so only while the block is idle, as the block itself does not enforce it.
module url_percent_decoder_core #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           output_limit_we,
  input  logic [upd_pkg::LIMIT_W-1:0]    output_limit_wdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [7:0] in_byte
  input  logic [7:0]                     s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [7:0] out_byte, [23:8] length
  output logic [23:0]                    m_axis_tdata,
  // [0] is_error
  output logic                           m_axis_tuser,
  output logic                           m_axis_tlast
);
  import upd_pkg::*;

  localparam logic [1:0] PH_NORMAL = 2'd0;
  localparam logic [1:0] PH_PCT    = 2'd1;
  localparam logic [1:0] PH_HEX1   = 2'd2;
  localparam logic [1:0] PH_SKIP   = 2'd3;

  localparam int CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

  logic [LIMIT_W-1:0]     output_limit;
  logic [1:0]             phase, phase_next;
  logic [3:0]             high_nibble, high_nibble_next;
  logic [COUNT_WIDTH-1:0] written_count, written_count_next;

  logic                   out_valid, out_valid_next;
  logic [BYTE_W-1:0]      out_byte, out_byte_next;
  logic                   out_error, out_error_next;
  logic                   out_last, out_last_next;
  logic [LENGTH_W-1:0]    out_length, out_length_next;

  logic                   in_fire;
  logic [7:0]             b;
  hex_digit_t             hd;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic [CMP_W-1:0]       count_max_w, limit_w, limit_eff;
  logic                   full;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign b             = s_axis_tdata;
  assign hd            = hex_decode(b);

  // Saturating count and effective limit: zero acts as one, and a limit the
  // counter cannot reach is clamped to the counter's maximum.
  always_comb begin
    count_inc   = (written_count == {COUNT_WIDTH{1'b1}}) ? written_count
                                                         : written_count + 1'b1;
    count_max_w = CMP_W'({COUNT_WIDTH{1'b1}});
    limit_w     = CMP_W'(output_limit);
    limit_eff   = limit_w;
    if (output_limit == '0) limit_eff = CMP_W'(1);
    if (limit_eff > count_max_w) limit_eff = count_max_w;
    full = CMP_W'(count_inc) >= limit_eff;
  end

  always_comb begin
    logic       do_emit;
    logic       do_bad;
    logic       term;
    logic [7:0] emit_byte;
    do_emit   = 1'b0;
    do_bad    = 1'b0;
    term      = 1'b0;
    emit_byte = b;

    phase_next         = phase;
    high_nibble_next   = high_nibble;
    written_count_next = written_count;
    out_valid_next     = out_valid && !m_axis_tready;
    out_byte_next      = out_byte;
    out_error_next     = out_error;
    out_last_next      = out_last;
    out_length_next    = out_length;

    if (in_fire) begin
      case (phase)
        PH_NORMAL: begin
          if (b == CHAR_PERCENT) begin
            phase_next = PH_PCT;
          end else if (b == CHAR_PLUS) begin
            do_emit   = 1'b1;
            emit_byte = CHAR_SPACE;
          end else begin
            do_emit = 1'b1;
            term    = (b == CHAR_NUL);
          end
        end
        PH_PCT: begin
          if (!hd.ok) begin
            do_bad = 1'b1;
          end else begin
            high_nibble_next = hd.nibble;
            phase_next       = PH_HEX1;
          end
        end
        PH_HEX1: begin
          if (!hd.ok) begin
            do_bad = 1'b1;
          end else begin
            do_emit   = 1'b1;
            emit_byte = {high_nibble, hd.nibble};
          end
        end
        default: begin
          if (b == CHAR_NUL) begin
            phase_next         = PH_NORMAL;
            written_count_next = '0;
          end
        end
      endcase

      if (do_emit) begin
        out_valid_next  = 1'b1;
        out_byte_next   = emit_byte;
        out_error_next  = 1'b0;
        out_last_next   = term || full;
        out_length_next = LENGTH_W'(count_inc);
        if (term) begin
          phase_next         = PH_NORMAL;
          written_count_next = '0;
        end else begin
          phase_next         = full ? PH_SKIP : PH_NORMAL;
          written_count_next = count_inc;
        end
      end

      // The error result reports the length before the failed escape.
      if (do_bad) begin
        out_valid_next  = 1'b1;
        out_byte_next   = CHAR_NUL;
        out_error_next  = 1'b1;
        out_last_next   = 1'b1;
        out_length_next = LENGTH_W'(written_count);
        if (b == CHAR_NUL) begin
          phase_next         = PH_NORMAL;
          written_count_next = '0;
        end else begin
          phase_next = PH_SKIP;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      output_limit  <= LIMIT_W'(256);
      phase         <= PH_NORMAL;
      high_nibble   <= 4'h0;
      written_count <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (output_limit_we) output_limit <= output_limit_wdata;
      phase         <= phase_next;
      high_nibble   <= high_nibble_next;
      written_count <= written_count_next;
      out_valid     <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_byte   <= out_byte_next;
    out_error  <= out_error_next;
    out_last   <= out_last_next;
    out_length <= out_length_next;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_length, out_byte};
  assign m_axis_tuser  = out_error;
  assign m_axis_tlast  = out_last;

endmodule
